// ===== hdl/c4glyph_pkg.sv =====
package c4glyph_pkg;

	// Default store depths
	localparam int DEF_MAX_SEGMENTS     = 256;
	localparam int DEF_GLYPH_ID_WORDS   = 1024;
	localparam int DEF_LOCATION_ENTRIES = 4096;

	// Input item kinds, carried in s_tuser
	localparam logic [1:0] ACT_WR_SEG = 2'd0;
	localparam logic [1:0] ACT_WR_GID = 2'd1;
	localparam logic [1:0] ACT_WR_LOC = 2'd2;
	localparam logic [1:0] ACT_LOOKUP = 2'd3;

	// Result status codes, carried in m_tuser
	localparam logic [1:0] ST_FOUND = 2'd0;
	localparam logic [1:0] ST_NONE  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	// Configuration register indexes
	localparam logic REG_SEG_COUNT = 1'b0;
	localparam logic REG_LOC_SHORT = 1'b1;

	localparam logic [8:0] SEG_COUNT_RESET = 9'd1;

endpackage

// ===== hdl/cmap4_char_to_glyph_lookup.sv =====
// Character-to-glyph lookup over a format-4 character map.
//
// Input stream (s_*): s_tuser selects the item kind: write segment, write
// glyph-id word, write location entry, or lookup. Writes cause no result;
// a lookup causes exactly one result on the output stream (m_*), with the
// status in m_tuser and glyph index / byte offset in m_tdata.
// Configuration: cfg_we writes register cfg_index (0 segment count,
// 1 short location format) with cfg_data; the user must write only while idle, unchecked.
//
// Writes leave the core idle. A lookup walks a token down the chain of
// segment cells, one segment per cycle. From the matching segment it
// steps through S_CHK, S_GID (glyph-id array only), S_LOC and S_OFF to
// S_EMIT, going to S_EMIT early on a miss or range error; the scan goes
// straight to S_EMIT when it stops on the sentinel or past the segment
// count, as does character zero.
// A new item is taken only when the previous lookup has left the core;
// a finished result waits in the output register while the receiver
// stalls, and the next item is still accepted.
// Reset clears the control state and the registers (segment count 1,
// long location format); store contents stay undefined until written.
module cmap4_char_to_glyph_lookup
	import c4glyph_pkg::*;
#(
	parameter int MAX_SEGMENTS     = DEF_MAX_SEGMENTS,
	parameter int GLYPH_ID_WORDS   = DEF_GLYPH_ID_WORDS,
	parameter int LOCATION_ENTRIES = DEF_LOCATION_ENTRIES
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// entry_index[11:0], end_code[27:12], start_code[43:28], id_delta[59:44],
	// range_offset[75:60], word_value[107:76], char_code[123:108], zero fill
	input  logic [127:0] s_tdata,
	// action[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// glyph_index[15:0], glyph_offset[47:16]
	output logic [47:0]  m_tdata,
	// status[1:0]
	output logic [1:0]   m_tuser,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [8:0]   cfg_data
);

	localparam int SEG_AW = $clog2(MAX_SEGMENTS);
	localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
	localparam int GID_AW = $clog2(GLYPH_ID_WORDS);
	localparam int LOC_AW = $clog2(LOCATION_ENTRIES);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_CHK, S_GID, S_LOC, S_OFF, S_EMIT
	} state_t;

	state_t      state_q;
	logic [8:0]  seg_count_q;
	logic        loc_short_q;
	logic [15:0] char_q;
	logic [CNT_W-1:0] seg_q;
	logic [15:0] gid_q;
	logic [1:0]  res_st_q;
	logic [15:0] res_gid_q;
	logic [31:0] res_off_q;
	logic [47:0] m_tdata_q;
	logic [1:0]  m_tuser_q;
	logic        m_tvalid_q;

	// input fields
	logic [11:0] in_entry;
	logic [15:0] in_end, in_start, in_delta, in_range, in_char;
	logic [31:0] in_word;
	assign in_entry = s_tdata[11:0];
	assign in_end   = s_tdata[27:12];
	assign in_start = s_tdata[43:28];
	assign in_delta = s_tdata[59:44];
	assign in_range = s_tdata[75:60];
	assign in_word  = s_tdata[107:76];
	assign in_char  = s_tdata[123:108];

	logic        s_xfer, m_free;
	logic [16:0] entry_ext;
	assign s_tready  = (state_q == S_IDLE);
	assign s_xfer    = s_tvalid && s_tready;
	assign m_free    = !m_tvalid_q || m_tready;
	assign entry_ext = 17'(in_entry);

	// clamped segment count
	logic [CNT_W-1:0] count_eff;
	assign count_eff = (13'(seg_count_q) > 13'(MAX_SEGMENTS)) ?
		CNT_W'(MAX_SEGMENTS) : CNT_W'(seg_count_q);

	// write strobes
	logic wr_seg, wr_gid, wr_loc, launch;
	assign wr_seg = s_xfer && (s_tuser == ACT_WR_SEG) && (entry_ext < 17'(MAX_SEGMENTS));
	assign wr_gid = s_xfer && (s_tuser == ACT_WR_GID) && (entry_ext < 17'(GLYPH_ID_WORDS));
	assign wr_loc = s_xfer && (s_tuser == ACT_WR_LOC) &&
		(entry_ext < 17'(LOCATION_ENTRIES));
	assign launch = s_xfer && (s_tuser == ACT_LOOKUP) && (in_char != 16'd0);

	// scan chain of segment cells
	logic [MAX_SEGMENTS-1:0] hit_v, tok_v;
	logic                    any_hit, scan_done, kill;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_SEGMENTS; gi++) begin : g_cell
			logic tok_in;
			if (gi == 0) begin : g_head
				assign tok_in = launch;
			end else begin : g_link
				assign tok_in = tok_v[gi-1];
			end
			c4glyph_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.wr_en     (wr_seg && (entry_ext[SEG_AW-1:0] == SEG_AW'(gi))),
				.wr_end    (in_end),
				.char_code (char_q),
				.tok_in    (tok_in),
				.kill      (kill),
				.hit       (hit_v[gi]),
				.tok_out   (tok_v[gi])
			);
		end
	endgenerate

	assign any_hit   = |hit_v;
	assign scan_done = (state_q == S_SCAN) && ((seg_q >= count_eff) || any_hit);
	assign kill      = scan_done;

	// segment side memories
	logic [15:0] start_mem [MAX_SEGMENTS];
	logic [15:0] delta_mem [MAX_SEGMENTS];
	logic [15:0] range_mem [MAX_SEGMENTS];
	logic [15:0] start_rd_q, delta_rd_q, range_rd_q;
	logic        seg_rd;
	assign seg_rd = (state_q == S_SCAN) && any_hit;

	always_ff @(posedge clk) begin
		if (wr_seg) begin
			start_mem[entry_ext[SEG_AW-1:0]] <= in_start;
			delta_mem[entry_ext[SEG_AW-1:0]] <= in_delta;
			range_mem[entry_ext[SEG_AW-1:0]] <= in_range;
		end
		if (seg_rd) begin
			start_rd_q <= start_mem[seg_q[SEG_AW-1:0]];
			delta_rd_q <= delta_mem[seg_q[SEG_AW-1:0]];
			range_rd_q <= range_mem[seg_q[SEG_AW-1:0]];
		end
	end

	// glyph-id index
	logic [15:0] gidx;
	logic [16:0] gidx_ext;
	logic        gidx_bad, gid_rd;
	assign gidx = 16'({1'b0, range_rd_q[15:1]}) + (char_q - start_rd_q)
		+ 16'(seg_q) - 16'(count_eff);
	assign gidx_ext = 17'(gidx);
	assign gidx_bad = gidx_ext >= 17'(GLYPH_ID_WORDS);
	assign gid_rd   = (state_q == S_CHK) && !(start_rd_q > char_q)
		&& (range_rd_q != 16'd0) && !gidx_bad;

	logic [15:0] gid_mem [GLYPH_ID_WORDS];
	logic [15:0] gid_rd_q;
	always_ff @(posedge clk) begin
		if (wr_gid) begin
			gid_mem[entry_ext[GID_AW-1:0]] <= in_word[15:0];
		end
		if (gid_rd) begin
			gid_rd_q <= gid_mem[gidx_ext[GID_AW-1:0]];
		end
	end

	// location table
	logic [16:0] gid_ext;
	logic        loc_rd;
	assign gid_ext = 17'(gid_q);
	assign loc_rd  = (state_q == S_LOC) && (gid_ext < 17'(LOCATION_ENTRIES));

	logic [31:0] loc_mem [LOCATION_ENTRIES];
	logic [31:0] loc_rd_q;
	always_ff @(posedge clk) begin
		if (wr_loc) begin
			loc_mem[entry_ext[LOC_AW-1:0]] <= in_word;
		end
		if (loc_rd) begin
			loc_rd_q <= loc_mem[gid_ext[LOC_AW-1:0]];
		end
	end

	logic [31:0] off_val;
	assign off_val = loc_short_q ? {loc_rd_q[30:0], 1'b0} : loc_rd_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_count_q <= SEG_COUNT_RESET;
			loc_short_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SEG_COUNT: seg_count_q <= cfg_data;
				REG_LOC_SHORT: loc_short_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// lookup sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
			seg_q      <= '0;
			char_q     <= '0;
			gid_q      <= '0;
			res_st_q   <= ST_NONE;
			res_gid_q  <= '0;
			res_off_q  <= '0;
			m_tdata_q  <= '0;
			m_tuser_q  <= ST_NONE;
		end else begin
			// S_EMIT reloads the output register itself
			if (m_tvalid_q && m_tready && (state_q != S_EMIT)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_xfer && (s_tuser == ACT_LOOKUP)) begin
						char_q <= in_char;
						seg_q  <= '0;
						if (in_char == 16'd0) begin
							res_st_q  <= ST_NONE;
							res_gid_q <= '0;
							res_off_q <= '0;
							state_q   <= S_EMIT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if ((seg_q >= count_eff) || (any_hit && (seg_q == count_eff - 1'b1))) begin
						res_st_q  <= ST_NONE;
						res_gid_q <= '0;
						res_off_q <= '0;
						state_q   <= S_EMIT;
					end else if (any_hit) begin
						state_q <= S_CHK;
					end else begin
						seg_q <= seg_q + 1'b1;
					end
				end
				S_CHK: begin
					if (start_rd_q > char_q) begin
						res_st_q  <= ST_NONE;
						res_gid_q <= '0;
						res_off_q <= '0;
						state_q   <= S_EMIT;
					end else if (range_rd_q == 16'd0) begin
						gid_q   <= char_q + delta_rd_q;
						state_q <= S_LOC;
					end else if (gidx_bad) begin
						res_st_q  <= ST_RANGE;
						res_gid_q <= '0;
						res_off_q <= '0;
						state_q   <= S_EMIT;
					end else begin
						state_q <= S_GID;
					end
				end
				S_GID: begin
					if (gid_rd_q == 16'd0) begin
						res_st_q  <= ST_NONE;
						res_gid_q <= '0;
						res_off_q <= '0;
						state_q   <= S_EMIT;
					end else begin
						gid_q   <= gid_rd_q + delta_rd_q;
						state_q <= S_LOC;
					end
				end
				S_LOC: begin
					if (loc_rd) begin
						state_q <= S_OFF;
					end else begin
						res_st_q  <= ST_RANGE;
						res_gid_q <= '0;
						res_off_q <= '0;
						state_q   <= S_EMIT;
					end
				end
				S_OFF: begin
					res_st_q  <= (off_val == 32'd0) ? ST_EMPTY : ST_FOUND;
					res_gid_q <= gid_q;
					res_off_q <= off_val;
					state_q   <= S_EMIT;
				end
				S_EMIT: begin
					if (m_free) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= res_st_q;
						m_tdata_q  <= {res_off_q, res_gid_q};
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTHESIS
	// a single token travels the chain
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(hit_v) <= 1)
		else $error("more than one segment cell hit");

	// hits only occur during the scan
	a_hit_scan: assert property (@(posedge clk) disable iff (!arst_n)
		any_hit |-> (state_q == S_SCAN))
		else $error("segment hit outside scan");

	// the chain is empty once the scan ends
	a_chain_clear: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |=> (tok_v == '0) && (hit_v == '0))
		else $error("token left in chain after scan");

	// scan never passes the segment count
	a_seg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (seg_q <= count_eff))
		else $error("scan ran past segment count");
`endif

endmodule

// ===== hdl/c4glyph_cell.sv =====
// One segment of the scan chain: holds an end code and passes the
// search token on to its neighbor while the character is above it.
module c4glyph_cell (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [15:0] wr_end,
	input  logic [15:0] char_code,
	input  logic        tok_in,
	input  logic        kill,
	output logic        hit,
	output logic        tok_out
);

	logic [15:0] end_q;
	logic        tok_q;

	// end code storage, no reset
	always_ff @(posedge clk) begin
		if (wr_en) begin
			end_q <= wr_end;
		end
	end

	// token position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in && !kill;
		end
	end

	assign hit     = tok_q && (char_code <= end_q);
	assign tok_out = tok_q && !hit;

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
	import c4glyph_pkg::*;

	localparam int SEGS  = DEF_MAX_SEGMENTS;
	localparam int GWORDS = DEF_GLYPH_ID_WORDS;
	localparam int LOCS  = DEF_LOCATION_ENTRIES;
	localparam int DRAIN = 300;
	// glyph-id words and location entries loaded before the first lookup
	localparam int GFILL = 64;
	localparam int LFILL = 192;

	typedef struct {
		logic [1:0]  act;
		logic [11:0] idx;
		logic [15:0] end_c;
		logic [15:0] start_c;
		logic [15:0] delta;
		logic [15:0] ro;
		logic [31:0] word;
		logic [15:0] ch;
	} glyph_req_t;

	// dc: the lookup reads a table entry never written, result not checked
	typedef struct {
		logic [1:0]  status;
		logic [15:0] gid;
		logic [31:0] off;
		bit          dc;
	} glyph_res_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [47:0]  m_tdata;
	logic [1:0]   m_tuser;
	logic         cfg_we;
	logic         cfg_index;
	logic [8:0]   cfg_data;

	cmap4_char_to_glyph_lookup dut (.*);

	// shadow copy of the block's tables and registers
	logic [15:0] sh_end [SEGS];
	logic [15:0] sh_start [SEGS];
	logic [15:0] sh_delta [SEGS];
	logic [15:0] sh_range [SEGS];
	logic [15:0] sh_gid [GWORDS];
	logic [31:0] sh_loc [LOCS];
	bit          sh_gid_ok [GWORDS];
	bit          sh_loc_ok [LOCS];
	int unsigned sh_seg_count;
	logic        sh_short;

	// layout of the table currently being exercised, used to aim characters
	logic [15:0] lay_end [SEGS];
	logic [15:0] lay_start [SEGS];
	int unsigned lay_n;

	glyph_req_t  pending_items[$];
	glyph_res_t  expected_glyphs[$];
	glyph_req_t  cur_item;
	bit          cur_taken;
	int          tx_gap, rx_gap, rx_hold;
	bit          no_idle, rx_hold_req;
	int          errors;

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	// character to glyph translation, as the block computes it
	function automatic glyph_res_t map_char(logic [15:0] c);
		int unsigned cnt, seg, idx, gid, w;
		logic [31:0] off;
		glyph_res_t r;
		r = '{ST_NONE, 16'd0, 32'd0, 1'b0};
		cnt = (sh_seg_count > SEGS) ? SEGS : sh_seg_count;
		seg = 0;
		if (c == 16'd0)
			return r;
		while (seg < cnt && c > sh_end[seg])
			seg++;
		if (seg >= cnt || seg == cnt - 1)
			return r;
		if (sh_start[seg] > c)
			return r;
		if (sh_range[seg] != 16'd0) begin
			idx = ((sh_range[seg] >> 1) + (c - sh_start[seg]) + seg - cnt) & 32'hFFFF;
			if (idx >= GWORDS)
				return '{ST_RANGE, 16'd0, 32'd0, 1'b0};
			if (!sh_gid_ok[idx])
				return '{ST_NONE, 16'd0, 32'd0, 1'b1};
			w = 32'(sh_gid[idx]);
			if (w == 0)
				return r;
			gid = (w + sh_delta[seg]) & 32'hFFFF;
		end else begin
			gid = (c + sh_delta[seg]) & 32'hFFFF;
		end
		if (gid >= LOCS)
			return '{ST_RANGE, 16'd0, 32'd0, 1'b0};
		if (!sh_loc_ok[gid])
			return '{ST_NONE, 16'd0, 32'd0, 1'b1};
		off = sh_loc[gid];
		if (sh_short)
			off = off << 1;
		if (off == 32'd0)
			return '{ST_EMPTY, gid[15:0], 32'd0, 1'b0};
		return '{ST_FOUND, gid[15:0], off, 1'b0};
	endfunction

	// apply one accepted transfer to the shadow tables
	task automatic absorb_item(glyph_req_t it);
		case (it.act)
			ACT_WR_SEG: if (it.idx < SEGS) begin
				sh_end[it.idx] = it.end_c;
				sh_start[it.idx] = it.start_c;
				sh_delta[it.idx] = it.delta;
				sh_range[it.idx] = it.ro;
			end
			ACT_WR_GID: if (it.idx < GWORDS) begin
				sh_gid[it.idx] = it.word[15:0];
				sh_gid_ok[it.idx] = 1'b1;
			end
			ACT_WR_LOC: if (it.idx < LOCS) begin
				sh_loc[it.idx] = it.word;
				sh_loc_ok[it.idx] = 1'b1;
			end
			default: expected_glyphs = {expected_glyphs, map_char(it.ch)};
		endcase
	endtask

	task automatic report(string what);
		errors++;
		$display("mismatch @%0t: %s", $realtime, what);
	endtask

	// sender: offer items from the queue, with random gaps
	always @(posedge clk)
		if (arst_n && s_tvalid && s_tready) begin
			absorb_item(cur_item);
			cur_taken = 1'b1;
		end

	always @(negedge clk) begin
		if (!s_tvalid || cur_taken) begin
			cur_taken = 1'b0;
			if (tx_gap == 0 && !no_idle && $urandom_range(0, 9) == 0)
				tx_gap = $urandom_range(1, 10);
			if (tx_gap > 0 || pending_items.size() == 0 || !arst_n) begin
				if (tx_gap > 0)
					tx_gap--;
				s_tvalid <= 1'b0;
			end else begin
				cur_item = pending_items.pop_front();
				s_tuser <= cur_item.act;
				s_tdata <= {4'd0, cur_item.ch, cur_item.word, cur_item.ro, cur_item.delta,
					cur_item.start_c, cur_item.end_c, cur_item.idx};
				s_tvalid <= 1'b1;
			end
		end
	end

	// long receiver hold, counted in cycles
	always @(posedge clk) begin
		if (rx_hold_req) begin
			rx_hold_req = 1'b0;
			rx_hold = 700;
		end else if (rx_hold > 0) begin
			rx_hold--;
		end
	end

	// receiver: random stalls, held off during the long hold
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
		end else begin
			if (rx_gap == 0 && !no_idle && $urandom_range(0, 9) == 0)
				rx_gap = $urandom_range(1, 10);
			if (rx_gap > 0) begin
				rx_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// check each result transfer against the oldest expectation
	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready) begin
			glyph_res_t exp_r;
			if (expected_glyphs.size() == 0) begin
				report($sformatf("unexpected result status=%0d", m_tuser));
			end else begin
				exp_r = expected_glyphs.pop_front();
				if (!exp_r.dc) begin
					if (m_tuser !== exp_r.status)
						report($sformatf("status %0d, want %0d", m_tuser, exp_r.status));
					if (m_tdata[15:0] !== exp_r.gid)
						report($sformatf("glyph index %h, want %h", m_tdata[15:0],
							exp_r.gid));
					if (m_tdata[47:16] !== exp_r.off)
						report($sformatf("glyph offset %h, want %h", m_tdata[47:16],
							exp_r.off));
				end
			end
		end

	task automatic queue_item(glyph_req_t it);
		pending_items = {pending_items, it};
	endtask

	function automatic glyph_req_t mk_item(logic [1:0] act, logic [11:0] idx);
		glyph_req_t it;
		it.act = act;
		it.idx = idx;
		it.end_c = 16'($urandom);
		it.start_c = 16'($urandom);
		it.delta = 16'($urandom);
		it.ro = 16'($urandom);
		it.word = $urandom;
		it.ch = 16'($urandom);
		return it;
	endfunction

	task automatic push_seg(int i, logic [15:0] e, logic [15:0] s, logic [15:0] d,
			logic [15:0] r);
		glyph_req_t it;
		it = mk_item(ACT_WR_SEG, 12'(i));
		it.end_c = e;
		it.start_c = s;
		it.delta = d;
		it.ro = r;
		queue_item(it);
		if (i < SEGS) begin
			lay_end[i] = e;
			lay_start[i] = s;
		end
	endtask

	task automatic push_word(logic [1:0] act, int i, logic [31:0] v);
		glyph_req_t it;
		it = mk_item(act, 12'(i));
		it.word = v;
		queue_item(it);
	endtask

	task automatic push_lookup(logic [15:0] c);
		glyph_req_t it;
		it = mk_item(ACT_LOOKUP, 12'($urandom));
		it.ch = c;
		queue_item(it);
	endtask

	// well-formed map of n segments with ascending end codes, sentinel last;
	// glyph-id and glyph indexes mostly land in the loaded part of the tables
	task automatic build_map(int unsigned n);
		int unsigned cnt, stp, lo, e, s, want, tgt;
		logic [15:0] d, r;
		cnt = (n > SEGS) ? SEGS : n;
		lay_n = cnt;
		if (cnt == 0)
			return;
		stp = 65535 / cnt;
		lo = 1;
		for (int k = 0; k < cnt - 1; k++) begin
			e = k * stp + $urandom_range(stp / 2, stp - 1);
			if (e < lo)
				e = lo;
			s = lo + $urandom_range(0, (e - lo) / 2);
			if ($urandom_range(0, 15) == 0)
				s = e + 1;
			if ($urandom_range(0, 1)) begin
				r = 16'd0;
				want = $urandom_range(0, 9) ? $urandom_range(0, LFILL - 41)
					: $urandom_range(LOCS - 40, LOCS + 40);
				d = 16'(want - s);
			end else begin
				tgt = $urandom_range(0, 9) ? $urandom_range(0, GFILL - 41)
					: $urandom_range(GWORDS - 40, GWORDS + 40);
				r = 16'((tgt + cnt - k) * 2 + $urandom_range(0, 1));
				d = $urandom_range(0, 3) ? 16'($urandom_range(0, 63)) : 16'($urandom);
			end
			if ($urandom_range(0, 19) == 0)
				d = 16'($urandom);
			if ($urandom_range(0, 19) == 0 && r != 0)
				r = 16'($urandom);
			push_seg(k, 16'(e), 16'(s), d, r);
			lo = e + 1;
		end
		e = $urandom_range(0, 2) ? 65535 : $urandom_range(lo, 65535);
		push_seg(cnt - 1, 16'(e), 16'(e), 16'd1, 16'd0);
	endtask

	function automatic logic [15:0] pick_char();
		int unsigned k;
		if (lay_n == 0 || $urandom_range(0, 9) < 3)
			return 16'($urandom);
		k = $urandom_range(0, lay_n - 1);
		return 16'(lay_start[k] + $urandom_range(0, 40) - 2);
	endfunction

	task automatic random_items(int num);
		int pick;
		for (int i = 0; i < num; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 62)
				push_lookup(pick_char());
			else if (pick < 77)
				push_word(ACT_WR_GID, $urandom_range(0, 15) ? $urandom_range(0, GWORDS - 1)
					: $urandom, $urandom_range(0, 5) ? $urandom_range(1, LFILL - 64)
					: $urandom);
			else if (pick < 92)
				push_word(ACT_WR_LOC, $urandom_range(0, 15) ? $urandom_range(0, LOCS - 1)
					: $urandom, $urandom_range(0, 7) ? $urandom : 32'd0);
			else
				queue_item(mk_item(ACT_WR_SEG, 12'($urandom_range(0, 3)
					? $urandom_range(0, SEGS - 1) : $urandom)));
		end
	endtask

	task automatic wait_idle();
		while (pending_items.size() != 0 || s_tvalid || expected_glyphs.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_reg(logic idx, int unsigned v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 9'(v);
		if (idx == REG_SEG_COUNT)
			sh_seg_count = v & 9'h1FF;
		else
			sh_short = v[0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// a count above the store depth runs on the full map loaded first
	int unsigned counts[] = '{511, 1, 2, 0, 20, 60, 8};

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = ACT_WR_SEG;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SEG_COUNT;
		cfg_data = '0;
		cur_taken = 1'b0;
		tx_gap = 0;
		rx_gap = 0;
		rx_hold = 0;
		no_idle = 1'b0;
		rx_hold_req = 1'b0;
		errors = 0;
		sh_seg_count = SEG_COUNT_RESET;
		sh_short = 1'b0;
		lay_n = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every segment and the low part of both tables before the first lookup
		build_map(SEGS);
		for (int i = 0; i < GFILL; i++)
			push_word(ACT_WR_GID, i, $urandom_range(0, 7) ? $urandom_range(1, LFILL - 64)
				: 32'd0);
		for (int i = 0; i < LFILL; i++)
			push_word(ACT_WR_LOC, i, $urandom_range(0, 9) ? $urandom : 32'd0);
		wait_idle();

		// directed: small hand-built map in short location format
		set_reg(REG_SEG_COUNT, 4);
		set_reg(REG_LOC_SHORT, 1);
		push_seg(0, 16'h0100, 16'h0080, 16'h0010, 16'h0000);
		push_seg(1, 16'h0200, 16'h0150, 16'h0000, 16'h0010);
		push_seg(2, 16'h0300, 16'h0250, 16'h0000, 16'hFFFE);
		push_seg(3, 16'h0400, 16'h0400, 16'h0001, 16'h0000);
		push_seg(300, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);    // ignored write
		push_word(ACT_WR_GID, 5, 32'd0);
		push_word(ACT_WR_GID, 6, 32'h0000_0123);
		push_word(ACT_WR_GID, 2000, 32'hFFFF_FFFF);              // ignored write
		push_word(ACT_WR_LOC, 12'h0A0, 32'd0);
		push_word(ACT_WR_LOC, 12'h0A1, 32'd5);
		push_word(ACT_WR_LOC, 12'h123, 32'h8000_0001);           // doubled, wraps
		push_word(ACT_WR_LOC, 12'hFFF, 32'hFFFF_FFFF);
		push_lookup(16'h0000);   // character zero
		push_lookup(16'h0010);   // start code above character
		push_lookup(16'h0090);   // delta map, empty glyph
		push_lookup(16'h0091);   // delta map, found
		push_lookup(16'h0150);   // zero glyph-id word
		push_lookup(16'h0151);   // glyph-id array, offset overflow
		push_lookup(16'h0260);   // glyph-id index out of range
		push_lookup(16'h0400);   // sentinel segment
		push_lookup(16'h0500);   // beyond every end code
		push_lookup(16'hFFFF);
		wait_idle();
		set_reg(REG_LOC_SHORT, 0);
		push_lookup(16'h0091);
		push_lookup(16'h0151);
		wait_idle();

		// random phases over several segment counts
		foreach (counts[p]) begin
			set_reg(REG_SEG_COUNT, counts[p]);
			set_reg(REG_LOC_SHORT, $urandom_range(0, 1));
			if (counts[p] < SEGS)
				build_map(counts[p]);
			if (p == 2)
				rx_hold_req = 1'b1;
			if (p == counts.size() - 1)
				no_idle = 1'b1;
			random_items(40);
			wait_idle();
		end

		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("tb_top failed");
		$finish;
	end

endmodule
